// ----- rtl/core/sic_pkg.sv -----
// shared types, widths and helper functions for the segment intersection classifier
package sic_pkg;

   // coordinate and derived widths
   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int SPAN_WIDTH  = COORD_WIDTH + 2;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [SPAN_WIDTH-1:0]  span_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [CROSS_WIDTH-1:0] cross_type;

   // relation codes
   typedef enum logic [1:0] {
      REL_DISJOINT = 2'd0,
      REL_POINT    = 2'd1,
      REL_OVERLAP  = 2'd2
   } relation_type;

   // direction and offset vectors after the first stage
   typedef struct packed {
      diff_type ux;
      diff_type uy;
      diff_type vx;
      diff_type vy;
      diff_type wx;
      diff_type wy;
      diff_type n1x;
      diff_type n1y;
   } diff_set_type;

   // degenerate segment flags
   typedef struct packed {
      logic upt;
      logic vpt;
      logic pt_eq;
      logic upt_on;
      logic vpt_on;
   } point_flags_type;

   // partial products after the second stage
   typedef struct packed {
      prod_type uxvy;
      prod_type uyvx;
      prod_type vxwy;
      prod_type vywx;
      prod_type uxwy;
      prod_type uywx;
   } prod_set_type;

   // collinear interval on the parameter line of the second segment
   typedef struct packed {
      span_type n0;
      span_type n1;
      span_type den;
   } span_set_type;

   // perp products after the third stage
   typedef struct packed {
      cross_type d;
      cross_type cu;
      cross_type cv;
   } cross_set_type;

   // n/d within [0,1], narrow operands
   function automatic logic in_unit_span(span_type n, span_type d);
      logic res;
      if (d > 0) begin
         res = (n >= 0) && (n <= d);
      end else begin
         res = (n <= 0) && (n >= d);
      end
      return res;
   endfunction

   // n/d within [0,1], perp product operands
   function automatic logic in_unit_cross(cross_type n, cross_type d);
      logic res;
      if (d > 0) begin
         res = (n >= 0) && (n <= d);
      end else begin
         res = (n <= 0) && (n >= d);
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/sic_diff.sv -----
// first stage: direction and offset vectors from the endpoints
module sic_diff (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  sic_pkg::coord_type     a_start_x,
   input  sic_pkg::coord_type     a_start_y,
   input  sic_pkg::coord_type     a_end_x,
   input  sic_pkg::coord_type     a_end_y,
   input  sic_pkg::coord_type     b_start_x,
   input  sic_pkg::coord_type     b_start_y,
   input  sic_pkg::coord_type     b_end_x,
   input  sic_pkg::coord_type     b_end_y,
   output logic                   valid_ff,
   output sic_pkg::diff_set_type  diff_ff
);

   sic_pkg::diff_set_type diff_in;

   // vector differences, sign extended by one bit
   always_comb begin
      diff_in.ux  = sic_pkg::diff_type'(a_end_x)   - sic_pkg::diff_type'(a_start_x);
      diff_in.uy  = sic_pkg::diff_type'(a_end_y)   - sic_pkg::diff_type'(a_start_y);
      diff_in.vx  = sic_pkg::diff_type'(b_end_x)   - sic_pkg::diff_type'(b_start_x);
      diff_in.vy  = sic_pkg::diff_type'(b_end_y)   - sic_pkg::diff_type'(b_start_y);
      diff_in.wx  = sic_pkg::diff_type'(a_start_x) - sic_pkg::diff_type'(b_start_x);
      diff_in.wy  = sic_pkg::diff_type'(a_start_y) - sic_pkg::diff_type'(b_start_y);
      diff_in.n1x = sic_pkg::diff_type'(a_end_x)   - sic_pkg::diff_type'(b_start_x);
      diff_in.n1y = sic_pkg::diff_type'(a_end_y)   - sic_pkg::diff_type'(b_start_y);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (valid_in) begin
         diff_ff <= diff_in;
      end
   end

endmodule

// ----- rtl/core/sic_prod.sv -----
// second stage: partial products, point flags and collinear interval set-up
module sic_prod (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_in,
   input  sic_pkg::diff_set_type    diff_in,
   output logic                     valid_ff,
   output sic_pkg::prod_set_type    prod_ff,
   output sic_pkg::point_flags_type flags_ff,
   output sic_pkg::span_set_type    span_ff
);

   sic_pkg::prod_set_type    prod_in;
   sic_pkg::point_flags_type flags_in;
   sic_pkg::span_set_type    span_in;
   sic_pkg::span_type        wx_s;
   sic_pkg::span_type        wy_s;
   sic_pkg::span_type        n0_sel;
   sic_pkg::span_type        n1_sel;
   sic_pkg::span_type        den_sel;
   sic_pkg::span_type        n0_neg;
   sic_pkg::span_type        n1_neg;

   // six perp product terms
   always_comb begin
      prod_in.uxvy = diff_in.ux * diff_in.vy;
      prod_in.uyvx = diff_in.uy * diff_in.vx;
      prod_in.vxwy = diff_in.vx * diff_in.wy;
      prod_in.vywx = diff_in.vy * diff_in.wx;
      prod_in.uxwy = diff_in.ux * diff_in.wy;
      prod_in.uywx = diff_in.uy * diff_in.wx;
   end

   // degenerate segments and on-segment tests, relative to each segment start
   always_comb begin
      wx_s           = sic_pkg::span_type'(diff_in.wx);
      wy_s           = sic_pkg::span_type'(diff_in.wy);
      flags_in.upt   = (diff_in.ux == 0) && (diff_in.uy == 0);
      flags_in.vpt   = (diff_in.vx == 0) && (diff_in.vy == 0);
      flags_in.pt_eq = (diff_in.wx == 0) && (diff_in.wy == 0);
      if (diff_in.vx != 0) begin
         flags_in.upt_on = sic_pkg::in_unit_span(wx_s, sic_pkg::span_type'(diff_in.vx));
      end else begin
         flags_in.upt_on = sic_pkg::in_unit_span(wy_s, sic_pkg::span_type'(diff_in.vy));
      end
      if (diff_in.ux != 0) begin
         flags_in.vpt_on = sic_pkg::in_unit_span(-wx_s, sic_pkg::span_type'(diff_in.ux));
      end else begin
         flags_in.vpt_on = sic_pkg::in_unit_span(-wy_s, sic_pkg::span_type'(diff_in.uy));
      end
   end

   // endpoints of the first segment on the second one's parameter line
   always_comb begin
      if (diff_in.vx != 0) begin
         n0_sel  = sic_pkg::span_type'(diff_in.wx);
         n1_sel  = sic_pkg::span_type'(diff_in.n1x);
         den_sel = sic_pkg::span_type'(diff_in.vx);
      end else begin
         n0_sel  = sic_pkg::span_type'(diff_in.wy);
         n1_sel  = sic_pkg::span_type'(diff_in.n1y);
         den_sel = sic_pkg::span_type'(diff_in.vy);
      end
      if (den_sel < 0) begin
         n0_neg      = -n0_sel;
         n1_neg      = -n1_sel;
         span_in.den = -den_sel;
      end else begin
         n0_neg      = n0_sel;
         n1_neg      = n1_sel;
         span_in.den = den_sel;
      end
      if (n0_neg > n1_neg) begin
         span_in.n0 = n1_neg;
         span_in.n1 = n0_neg;
      end else begin
         span_in.n0 = n0_neg;
         span_in.n1 = n1_neg;
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (valid_in) begin
         prod_ff  <= prod_in;
         flags_ff <= flags_in;
         span_ff  <= span_in;
      end
   end

endmodule

// ----- rtl/core/sic_cross.sv -----
// third stage: perp products and collinear overlap class
module sic_cross (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_in,
   input  sic_pkg::prod_set_type    prod_in,
   input  sic_pkg::point_flags_type flags_in,
   input  sic_pkg::span_set_type    span_in,
   output logic                     valid_ff,
   output sic_pkg::cross_set_type   cross_ff,
   output sic_pkg::point_flags_type flags_ff,
   output sic_pkg::relation_type    par_rel_ff
);

   sic_pkg::cross_set_type cross_in;
   sic_pkg::relation_type  par_rel_in;
   sic_pkg::span_type      lo;
   sic_pkg::span_type      hi;

   // perp products
   always_comb begin
      cross_in.d  = sic_pkg::cross_type'(prod_in.uxvy) - sic_pkg::cross_type'(prod_in.uyvx);
      cross_in.cu = sic_pkg::cross_type'(prod_in.uxwy) - sic_pkg::cross_type'(prod_in.uywx);
      cross_in.cv = sic_pkg::cross_type'(prod_in.vxwy) - sic_pkg::cross_type'(prod_in.vywx);
   end

   // interval clipped to [0, den]
   always_comb begin
      lo = (span_in.n0 < 0) ? '0 : span_in.n0;
      hi = (span_in.n1 > span_in.den) ? span_in.den : span_in.n1;
      priority if ((span_in.n0 > span_in.den) || (span_in.n1 < 0)) begin
         par_rel_in = sic_pkg::REL_DISJOINT;
      end else if (lo == hi) begin
         par_rel_in = sic_pkg::REL_POINT;
      end else begin
         par_rel_in = sic_pkg::REL_OVERLAP;
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (valid_in) begin
         cross_ff   <= cross_in;
         flags_ff   <= flags_in;
         par_rel_ff <= par_rel_in;
      end
   end

endmodule

// ----- rtl/core/sic_decide.sv -----
// fourth stage: parameter range tests and final classification
module sic_decide (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_in,
   input  sic_pkg::cross_set_type   cross_in,
   input  sic_pkg::point_flags_type flags_in,
   input  sic_pkg::relation_type    par_rel_in,
   output logic                     valid_ff,
   output sic_pkg::relation_type    relation_ff
);

   sic_pkg::relation_type relation_in;
   logic                  skew_hit;

   // skew: both parameters within [0,1]; parallel: disjoint unless collinear, then degenerate cases, then interval
   always_comb begin
      skew_hit = sic_pkg::in_unit_cross(cross_in.cv, cross_in.d)
              && sic_pkg::in_unit_cross(cross_in.cu, cross_in.d);
      priority if (cross_in.d != 0) begin
         relation_in = skew_hit ? sic_pkg::REL_POINT : sic_pkg::REL_DISJOINT;
      end else if ((cross_in.cu != 0) || (cross_in.cv != 0)) begin
         relation_in = sic_pkg::REL_DISJOINT;
      end else if (flags_in.upt && flags_in.vpt) begin
         relation_in = flags_in.pt_eq ? sic_pkg::REL_POINT : sic_pkg::REL_DISJOINT;
      end else if (flags_in.upt) begin
         relation_in = flags_in.upt_on ? sic_pkg::REL_POINT : sic_pkg::REL_DISJOINT;
      end else if (flags_in.vpt) begin
         relation_in = flags_in.vpt_on ? sic_pkg::REL_POINT : sic_pkg::REL_DISJOINT;
      end else begin
         relation_in = par_rel_in;
      end
   end

   // strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (valid_in) begin
         relation_ff <= relation_in;
      end
   end

endmodule

// ----- rtl/core/segment_intersection_classifier.sv -----
// top level of the 2d segment pair intersection classifier
//
//   channel   ports                        transfer
//   request   start, busy, req_*           start high and busy low at a rising edge
//   response  rsp_strobe, rsp_relation     rsp_strobe high for one cycle, always taken
//
// one segment pair enters per cycle while busy is low; its relation is registered
// through the difference, multiply, perp product and decision stages before it is
// on the response ports.
// busy is high only while reset is held; reset clears the stage valid bits and
// drops any pairs in flight. the response side cannot stall, so the pipeline
// never holds and no pair is lost or repeated.
module segment_intersection_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [sic_pkg::COORD_WIDTH-1:0] req_a_start_x,
   input  logic signed [sic_pkg::COORD_WIDTH-1:0] req_a_start_y,
   input  logic signed [sic_pkg::COORD_WIDTH-1:0] req_a_end_x,
   input  logic signed [sic_pkg::COORD_WIDTH-1:0] req_a_end_y,
   input  logic signed [sic_pkg::COORD_WIDTH-1:0] req_b_start_x,
   input  logic signed [sic_pkg::COORD_WIDTH-1:0] req_b_start_y,
   input  logic signed [sic_pkg::COORD_WIDTH-1:0] req_b_end_x,
   input  logic signed [sic_pkg::COORD_WIDTH-1:0] req_b_end_y,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_relation
);

   logic                     accept;
   logic                     s1_valid;
   logic                     s2_valid;
   logic                     s3_valid;
   sic_pkg::diff_set_type    s1_diff;
   sic_pkg::prod_set_type    s2_prod;
   sic_pkg::point_flags_type s2_flags;
   sic_pkg::span_set_type    s2_span;
   sic_pkg::cross_set_type   s3_cross;
   sic_pkg::point_flags_type s3_flags;
   sic_pkg::relation_type    s3_par_rel;
   sic_pkg::relation_type    relation;

   // request transfer
   assign busy   = reset;
   assign accept = start && !busy;

   sic_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .a_start_x (req_a_start_x),
      .a_start_y (req_a_start_y),
      .a_end_x   (req_a_end_x),
      .a_end_y   (req_a_end_y),
      .b_start_x (req_b_start_x),
      .b_start_y (req_b_start_y),
      .b_end_x   (req_b_end_x),
      .b_end_y   (req_b_end_y),
      .valid_ff  (s1_valid),
      .diff_ff   (s1_diff)
   );

   sic_prod u_prod (
      .clock    (clock),
      .reset    (reset),
      .valid_in (s1_valid),
      .diff_in  (s1_diff),
      .valid_ff (s2_valid),
      .prod_ff  (s2_prod),
      .flags_ff (s2_flags),
      .span_ff  (s2_span)
   );

   sic_cross u_cross (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (s2_valid),
      .prod_in    (s2_prod),
      .flags_in   (s2_flags),
      .span_in    (s2_span),
      .valid_ff   (s3_valid),
      .cross_ff   (s3_cross),
      .flags_ff   (s3_flags),
      .par_rel_ff (s3_par_rel)
   );

   sic_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .valid_in    (s3_valid),
      .cross_in    (s3_cross),
      .flags_in    (s3_flags),
      .par_rel_in  (s3_par_rel),
      .valid_ff    (rsp_strobe),
      .relation_ff (relation)
   );

   // response fields
   assign rsp_relation = relation;

`ifndef SYNTHESIS
   // every response comes from an earlier request transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 4))
      else $error("response without a matching request transfer");

   // every transfer yields a response
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("request transfer lost in the pipeline");

   // a skew pair never reports an overlap
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid && (s3_cross.d != 0)) |=> (rsp_relation != sic_pkg::REL_OVERLAP))
      else $error("overlap reported for non-parallel segments");
`endif

endmodule
